### src/fqp_pkg.sv
`timescale 1ns / 1ps
// Package for the queue with purge: command codes, beat structs and FSM states.
// Depends on nothing; used by the top level.
package fqp_pkg;

	// Widths fixed by the beat format.
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 5;

	typedef enum logic [1:0] {
		CMD_ENQUEUE = 2'd0,
		CMD_POLL    = 2'd1,
		CMD_REMOVE  = 2'd2,
		CMD_CLEAR   = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t               command;
		logic [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic               ok;
		logic [VALUE_W-1:0] value_out;
		logic [COUNT_W-1:0] removed_count;
		logic [COUNT_W-1:0] entry_count;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POLL,
		ST_PURGE
	} state_t;

endpackage

### src/fifo_queue_with_purge_top.sv
`timescale 1ns / 1ps
// Top level of the queue with purge: command FSM, ring pointers and the slot RAM.
// Depends on fqp_pkg and fqp_ram.

// A command beat is taken when start is high and busy is low; exactly one result beat
// follows, shown for one cycle with done high, and it cannot be held off. Enqueue, clear,
// poll on an empty queue and remove on an empty queue give their result in the cycle after
// acceptance. Poll on a non-empty queue passes through the poll state, because the oldest
// word comes from the slot RAM with registered read data. Remove on a non-empty queue
// streams every held entry through the RAM read port, one per cycle, and writes the kept
// ones back toward the head through the write port. Busy is high from acceptance until the
// result beat of a poll or remove on a non-empty queue is shown.
module fifo_queue_with_purge_top #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  fqp_pkg::req_t req,
	output logic          done,
	output fqp_pkg::rsp_t rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	fqp_pkg::state_t state_q, state_d;
	logic [AW-1:0]   head_q, head_d, tail_q, tail_d;
	logic [CW-1:0]   count_q, count_d;
	logic [AW-1:0]   rd_q, rd_d, wr_q, wr_d;
	logic [CW-1:0]   left_q, left_d, kept_q, kept_d;
	logic [DATA_WIDTH-1:0] key_q, key_d;
	logic            done_q, done_d;
	fqp_pkg::rsp_t   rsp_q, rsp_d;

	logic                  ram_we, ram_re;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata, din;
	logic                  keep;
	logic [AW-1:0]         wr_n;
	logic [CW-1:0]         kept_n;

	function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
		return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
	endfunction

	assign din  = DATA_WIDTH'(req.value);
	assign busy = (state_q != fqp_pkg::ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	fqp_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Purge step: decide whether the word arriving from the RAM is kept.
	assign keep   = (ram_rdata != key_q);
	assign wr_n   = keep ? next_idx(wr_q) : wr_q;
	assign kept_n = kept_q + CW'(keep);

	// Next state, RAM controls and result beat.
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		rd_d      = rd_q;
		wr_d      = wr_q;
		left_d    = left_q;
		kept_d    = kept_q;
		key_d     = key_q;
		done_d    = 1'b0;
		rsp_d     = rsp_q;
		ram_we    = 1'b0;
		ram_waddr = tail_q;
		ram_wdata = din;
		ram_re    = 1'b0;
		ram_raddr = head_q;

		unique case (state_q)
			fqp_pkg::ST_IDLE: begin
				if (start) begin
					rsp_d.ok            = 1'b1;
					rsp_d.value_out     = '0;
					rsp_d.removed_count = '0;
					rsp_d.entry_count   = fqp_pkg::COUNT_W'(count_q);
					unique case (req.command)
						fqp_pkg::CMD_ENQUEUE: begin
							done_d = 1'b1;
							if (count_q == CW'(DEPTH)) begin
								rsp_d.ok = 1'b0;
							end else begin
								ram_we            = 1'b1;
								tail_d            = next_idx(tail_q);
								count_d           = count_q + CW'(1);
								rsp_d.entry_count = fqp_pkg::COUNT_W'(count_q + CW'(1));
							end
						end
						fqp_pkg::CMD_POLL: begin
							if (count_q == '0) begin
								done_d   = 1'b1;
								rsp_d.ok = 1'b0;
							end else begin
								ram_re  = 1'b1;
								state_d = fqp_pkg::ST_POLL;
							end
						end
						fqp_pkg::CMD_REMOVE: begin
							key_d = din;
							if (count_q == '0) begin
								done_d = 1'b1;
							end else begin
								ram_re  = 1'b1;
								rd_d    = next_idx(head_q);
								left_d  = count_q - CW'(1);
								wr_d    = head_q;
								kept_d  = '0;
								state_d = fqp_pkg::ST_PURGE;
							end
						end
						fqp_pkg::CMD_CLEAR: begin
							done_d            = 1'b1;
							head_d            = '0;
							tail_d            = '0;
							count_d           = '0;
							rsp_d.entry_count = '0;
						end
					endcase
				end
			end
			fqp_pkg::ST_POLL: begin
				done_d              = 1'b1;
				rsp_d.ok            = 1'b1;
				rsp_d.value_out     = fqp_pkg::VALUE_W'(ram_rdata);
				rsp_d.removed_count = '0;
				head_d              = next_idx(head_q);
				count_d             = count_q - CW'(1);
				rsp_d.entry_count   = fqp_pkg::COUNT_W'(count_q - CW'(1));
				state_d             = fqp_pkg::ST_IDLE;
			end
			fqp_pkg::ST_PURGE: begin
				// Kept words move down to the write pointer, which never passes the reads.
				if (keep) begin
					ram_we    = 1'b1;
					ram_waddr = wr_q;
					ram_wdata = ram_rdata;
				end
				if (left_q != '0) begin
					ram_re    = 1'b1;
					ram_raddr = rd_q;
					rd_d      = next_idx(rd_q);
					left_d    = left_q - CW'(1);
					wr_d      = wr_n;
					kept_d    = kept_n;
				end else begin
					done_d              = 1'b1;
					tail_d              = wr_n;
					count_d             = kept_n;
					rsp_d.ok            = 1'b1;
					rsp_d.value_out     = '0;
					rsp_d.removed_count = fqp_pkg::COUNT_W'(count_q - kept_n);
					rsp_d.entry_count   = fqp_pkg::COUNT_W'(kept_n);
					state_d             = fqp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fqp_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fqp_pkg::ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			rd_q    <= '0;
			wr_q    <= '0;
			left_q  <= '0;
			kept_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			rd_q    <= rd_d;
			wr_q    <= wr_d;
			left_q  <= left_d;
			kept_q  <= kept_d;
			done_q  <= done_d;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		key_q <= key_d;
		rsp_q <= rsp_d;
	end

endmodule

### src/fqp_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Depends on nothing.
module fqp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, with registered read data.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
